// ===== rtl/fas_pkg.sv =====
// Shared types and defaults for the fuzzy alignment score block.
package fas_pkg;

  localparam int unsigned PATTERN_MAX_DEF = 32;
  localparam int unsigned SCORE_WIDTH_DEF = 16;

  localparam int unsigned BEST_WIDTH = 15;

  localparam logic [6:0] MATCH_RST  = 7'd2;
  localparam logic [7:0] ACCENT_RST = 8'sd1;
  localparam logic [7:0] GAP_RST    = 8'hFF;

  typedef struct packed {
    logic [6:0] match_score;
    logic [7:0] accent_score;
    logic [7:0] gap_score;
  } cfg_t;

endpackage

// ===== rtl/fuzzy_alignment_score_top.sv =====
// Top level: command port, column sequencer, pattern and column RAMs.
// A pattern byte (op 0) is taken without raising busy. A text byte (op 1)
// holds busy while the byte is scored: the single cell unit works through
// one pattern row per cycle, fed by one read of the pattern RAM and column
// RAM per cycle, then S_TAIL settles the running maximum and S_DONE closes
// the byte; an empty pattern goes straight to S_DONE. On a text byte
// marked last, best_valid_o pulses for one cycle with best_score_o; the
// receiver cannot stall it. No clearing pass is needed after reset.
module fuzzy_alignment_score_top #(
  parameter int unsigned PATTERN_MAX = fas_pkg::PATTERN_MAX_DEF,
  parameter int unsigned SCORE_WIDTH = fas_pkg::SCORE_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        op_i,
  input  logic [7:0]  symbol_i,
  input  logic        last_i,
  output logic        best_valid_o,
  output logic [14:0] best_score_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int unsigned LW = $clog2(PATTERN_MAX + 1);
  localparam int unsigned BW = SCORE_WIDTH - 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_TAIL,
    S_DONE
  } state_e;

  state_e                 state_q;
  fas_pkg::cfg_t          cfg;
  logic [LW-1:0]          len_q;
  logic [LW-1:0]          idx_q;
  logic [LW-1:0]          idx_nxt;
  logic [LW-1:0]          len_eff;
  logic                   open_q;
  logic                   first_q;
  logic                   last_q;
  logic [7:0]             sym_q;
  logic [BW-1:0]          best_q;
  logic [SCORE_WIDTH-1:0] cell_q;
  logic                   cell_vld_q;
  logic [SCORE_WIDTH-1:0] diag_q;
  logic [SCORE_WIDTH-1:0] cell_res;
  logic [SCORE_WIDTH-1:0] left;
  logic [7:0]             pat;
  logic                   accept;
  logic                   pat_we;
  logic [AW-1:0]          raddr;
  logic [31:0]            best_ext;

  assign busy    = (state_q != S_IDLE);
  assign accept  = start && !busy;
  assign idx_nxt = idx_q + LW'(1);
  // a pattern byte after the pattern was closed starts a fresh pattern
  assign len_eff = open_q ? len_q : '0;
  assign pat_we  = accept && !op_i && (len_eff < LW'(PATTERN_MAX));
  assign raddr   = (state_q == S_RUN) ? idx_nxt[AW-1:0] : '0;
  assign best_ext = {{(32-BW){1'b0}}, best_q};

  fas_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fas_ram #(
    .WIDTH (8),
    .DEPTH (PATTERN_MAX)
  ) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (pat_we),
    .waddr_i (len_eff[AW-1:0]),
    .wdata_i (symbol_i),
    .raddr_i (raddr),
    .rdata_o (pat)
  );

  fas_ram #(
    .WIDTH (SCORE_WIDTH),
    .DEPTH (PATTERN_MAX)
  ) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == S_RUN),
    .waddr_i (idx_q[AW-1:0]),
    .wdata_i (cell_res),
    .raddr_i (raddr),
    .rdata_o (left)
  );

  fas_cell #(
    .SCORE_WIDTH (SCORE_WIDTH)
  ) u_cell (
    .cfg_i       (cfg),
    .pat_i       (pat),
    .sym_i       (sym_q),
    .left_i      (left),
    .up_i        (cell_q),
    .diag_i      (diag_q),
    .first_col_i (first_q),
    .first_row_i (idx_q == '0),
    .cell_o      (cell_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      len_q        <= '0;
      idx_q        <= '0;
      open_q       <= 1'b1;
      first_q      <= 1'b1;
      last_q       <= 1'b0;
      best_q       <= '0;
      cell_vld_q   <= 1'b0;
      best_valid_o <= 1'b0;
    end else begin
      best_valid_o <= (state_q == S_DONE) && last_q;
      cell_vld_q   <= (state_q == S_RUN);
      // running maximum is taken from the registered cell value cell_q
      if (cell_vld_q && !cell_q[SCORE_WIDTH-1] && (cell_q[BW-1:0] > best_q)) begin
        best_q <= cell_q[BW-1:0];
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept && !op_i) begin
            if (!open_q) begin
              best_q  <= '0;
              first_q <= 1'b1;
            end
            len_q  <= pat_we ? (len_eff + LW'(1)) : len_eff;
            open_q <= !last_i;
          end else if (accept) begin
            open_q <= 1'b0;
            sym_q  <= symbol_i;
            last_q <= last_i;
            idx_q  <= '0;
            state_q <= (len_q == '0) ? S_DONE : S_RUN;
          end
        end
        S_RUN: begin
          cell_q <= cell_res;
          diag_q <= left;
          if (idx_nxt == len_q) begin
            state_q <= S_TAIL;
          end else begin
            idx_q <= idx_nxt;
          end
        end
        S_TAIL: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          // a closed text starts over with a fresh first column
          first_q <= last_q;
          if (last_q) begin
            best_score_o <= (best_ext > 32'd32767) ? 15'h7FFF : best_ext[14:0];
            best_q       <= '0;
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/fas_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fas_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/fas_cfg.sv =====
// APB register file for the match, accent and gap scores.
module fas_cfg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output fas_pkg::cfg_t    cfg_o
);

  typedef enum logic [1:0] {
    REG_MATCH  = 2'd0,
    REG_ACCENT = 2'd1,
    REG_GAP    = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_e;

  reg_idx_e      idx;
  logic          wr_en;
  fas_pkg::cfg_t cfg_q;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.match_score  <= fas_pkg::MATCH_RST;
      cfg_q.accent_score <= fas_pkg::ACCENT_RST;
      cfg_q.gap_score    <= fas_pkg::GAP_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_MATCH:  cfg_q.match_score  <= pwdata[6:0];
        REG_ACCENT: cfg_q.accent_score <= pwdata[7:0];
        REG_GAP:    cfg_q.gap_score    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MATCH:  prdata = {25'd0, cfg_q.match_score};
      REG_ACCENT: prdata = {{24{cfg_q.accent_score[7]}}, cfg_q.accent_score};
      REG_GAP:    prdata = {{24{cfg_q.gap_score[7]}}, cfg_q.gap_score};
      default:    prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/fas_cell.sv =====
// Shared cell unit: letter score, gap and diagonal moves, max and saturation.
module fas_cell #(
  parameter int unsigned SCORE_WIDTH = fas_pkg::SCORE_WIDTH_DEF
) (
  input  fas_pkg::cfg_t           cfg_i,
  input  logic [7:0]              pat_i,
  input  logic [7:0]              sym_i,
  input  logic [SCORE_WIDTH-1:0]  left_i,
  input  logic [SCORE_WIDTH-1:0]  up_i,
  input  logic [SCORE_WIDTH-1:0]  diag_i,
  input  logic                    first_col_i,
  input  logic                    first_row_i,
  output logic [SCORE_WIDTH-1:0]  cell_o
);

  localparam int unsigned EW = SCORE_WIDTH + 1;

  function automatic logic in_e_set(input logic [7:0] v);
    return (v == 8'h65) || (v == 8'hC3) || (v == 8'hA9) || (v == 8'h88) ||
           (v == 8'h89) || (v == 8'h8A) || (v == 8'h8B) || (v == 8'hA8) ||
           (v == 8'hAA) || (v == 8'hAB);
  endfunction

  function automatic logic in_a_set(input logic [7:0] v);
    return (v == 8'h61) || (v == 8'hC3) || (v == 8'hA0) || (v == 8'hA1) ||
           (v == 8'hA2);
  endfunction

  logic [8:0]    diff;
  logic          is_match;
  logic          is_accent;
  logic [7:0]    letter;
  logic [EW-1:0] letter_e;
  logic [EW-1:0] gap_e;
  logic [EW-1:0] up_g;
  logic [EW-1:0] left_g;
  logic [EW-1:0] diag_s;
  logic [EW-1:0] best_gap;
  logic [EW-1:0] raw;

  // signed byte difference; case folding is a distance of 32
  assign diff      = {pat_i[7], pat_i} - {sym_i[7], sym_i};
  assign is_match  = (diff == 9'd0) || (diff == 9'd32) || (diff == 9'h1E0);
  assign is_accent = (in_e_set(pat_i) && in_e_set(sym_i)) ||
                     (in_a_set(pat_i) && in_a_set(sym_i));

  always_comb begin
    if (is_match) begin
      letter = {1'b0, cfg_i.match_score};
    end else if (is_accent) begin
      letter = cfg_i.accent_score;
    end else begin
      letter = 8'd0 - {1'b0, cfg_i.match_score};
    end
  end

  assign letter_e = {{(EW-8){letter[7]}}, letter};
  assign gap_e    = {{(EW-8){cfg_i.gap_score[7]}}, cfg_i.gap_score};
  assign up_g     = {up_i[SCORE_WIDTH-1], up_i} + gap_e;
  assign left_g   = {left_i[SCORE_WIDTH-1], left_i} + gap_e;
  assign diag_s   = {diag_i[SCORE_WIDTH-1], diag_i} + letter_e;

  always_comb begin
    best_gap = ($signed(up_g) >= $signed(left_g)) ? up_g : left_g;
    if (first_col_i && first_row_i) begin
      raw = letter_e;
    end else if (first_col_i) begin
      raw = ($signed(up_g) >= $signed(letter_e)) ? up_g : letter_e;
    end else if (first_row_i) begin
      raw = ($signed(left_g) >= $signed(letter_e)) ? left_g : letter_e;
    end else begin
      raw = ($signed(best_gap) >= $signed(diag_s)) ? best_gap : diag_s;
    end
  end

  // top two bits disagree: outside the signed cell range
  always_comb begin
    if (raw[EW-1] != raw[EW-2]) begin
      cell_o = raw[EW-1] ? {1'b1, {(SCORE_WIDTH-1){1'b0}}}
                         : {1'b0, {(SCORE_WIDTH-1){1'b1}}};
    end else begin
      cell_o = raw[SCORE_WIDTH-1:0];
    end
  end

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for fuzzy_alignment_score_top: queued command driver, result monitor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PATTERN_MAX = fas_pkg::PATTERN_MAX_DEF;
  localparam int          CELL_MAX    = 32767;
  localparam int          CELL_MIN    = -32768;
  localparam int          LAT_CYCLES  = PATTERN_MAX + 8;
  localparam int          DRAIN_LIMIT = 20000;

  localparam logic OP_PATTERN = 1'b0;
  localparam logic OP_TEXT    = 1'b1;

  localparam int REG_MATCH  = 0;
  localparam int REG_ACCENT = 1;
  localparam int REG_GAP    = 2;

  typedef struct packed {
    logic       op;
    logic [7:0] sym;
    logic       lst;
  } symbol_cmd_t;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        start    = 1'b0;
  logic        busy;
  logic        op_i     = 1'b0;
  logic [7:0]  symbol_i = 8'h00;
  logic        last_i   = 1'b0;
  logic        best_valid_o;
  logic [14:0] best_score_o;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [3:0]  paddr    = 4'h0;
  logic [31:0] pwdata   = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  fuzzy_alignment_score_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .op_i         (op_i),
    .symbol_i     (symbol_i),
    .last_i       (last_i),
    .best_valid_o (best_valid_o),
    .best_score_o (best_score_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // predictor state, reset values
  int          cfg_match  = 2;
  int          cfg_accent = 1;
  int          cfg_gap    = -1;
  logic [7:0]  pat_mem [PATTERN_MAX];
  int unsigned pat_len    = 0;
  int          col_scores [PATTERN_MAX];
  int          run_best   = 0;
  logic        first_col  = 1'b1;
  logic        pat_open   = 1'b1;

  symbol_cmd_t cmd_q [$];
  symbol_cmd_t next_cmd;
  logic [14:0] best_q [$];
  logic [14:0] best_want;
  int          cmds_queued = 0;
  int          cmds_taken  = 0;
  int          idle_pct    = 0;
  int          errors      = 0;
  logic [7:0]  gen_pat [$];

  function automatic logic in_e_set(logic [7:0] v);
    case (v)
      8'h65, 8'hC3, 8'hA9, 8'h88, 8'h89, 8'h8A, 8'h8B, 8'hA8, 8'hAA, 8'hAB: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic in_a_set(logic [7:0] v);
    case (v)
      8'h61, 8'hC3, 8'hA0, 8'hA1, 8'hA2: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic int letter_score(logic [7:0] p, logic [7:0] t);
    int d;
    d = int'($signed(p)) - int'($signed(t));
    if (d == 0 || d == 32 || d == -32) return cfg_match;
    if (in_e_set(p) && in_e_set(t)) return cfg_accent;
    if (in_a_set(p) && in_a_set(t)) return cfg_accent;
    return -cfg_match;
  endfunction

  function automatic int max_int(int a, int b);
    return (a >= b) ? a : b;
  endfunction

  function automatic int sat_cell(int v);
    if (v > CELL_MAX) return CELL_MAX;
    if (v < CELL_MIN) return CELL_MIN;
    return v;
  endfunction

  // Updates the alignment state for one accepted item, queues the best score on a last text byte.
  task automatic score_symbol(input logic op, input logic [7:0] sym, input logic lst);
    int          s;
    int          cell_val;
    int          left;
    int          up;
    int          diag;
    int unsigned r;
    if (op == OP_PATTERN) begin
      if (!pat_open) begin
        pat_len   = 0;
        run_best  = 0;
        first_col = 1'b1;
        pat_open  = 1'b1;
      end
      if (pat_len < PATTERN_MAX) begin
        pat_mem[pat_len] = sym;
        pat_len++;
      end
      if (lst) pat_open = 1'b0;
    end else begin
      pat_open = 1'b0;
      diag = 0;
      up   = 0;
      for (r = 0; r < pat_len; r++) begin
        s    = letter_score(pat_mem[r], sym);
        left = col_scores[r];
        if (first_col) begin
          cell_val = (r == 0) ? s : max_int(up + cfg_gap, s);
        end else if (r == 0) begin
          cell_val = max_int(left + cfg_gap, s);
        end else begin
          cell_val = max_int(max_int(up + cfg_gap, left + cfg_gap), diag + s);
        end
        cell_val      = sat_cell(cell_val);
        diag          = left;
        col_scores[r] = cell_val;
        up            = cell_val;
        if (cell_val > run_best) run_best = cell_val;
      end
      first_col = 1'b0;
      if (lst) begin
        best_q.push_back(15'((run_best > CELL_MAX) ? CELL_MAX : run_best));
        run_best  = 0;
        first_col = 1'b1;
      end
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        score_symbol(op_i, symbol_i, last_i);
        cmds_taken++;
      end
      if (!start || !busy) begin
        if (cmd_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          next_cmd = cmd_q.pop_front();
          start    <= 1'b1;
          op_i     <= next_cmd.op;
          symbol_i <= next_cmd.sym;
          last_i   <= next_cmd.lst;
        end else begin
          start    <= 1'b0;
          op_i     <= 1'($urandom);
          symbol_i <= 8'($urandom);
          last_i   <= 1'($urandom);
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && best_valid_o) begin
      if (best_q.size() == 0) begin
        $error("best_score: expected no result, got %0d", best_score_o);
        errors++;
      end else begin
        best_want = best_q.pop_front();
        if (best_score_o !== best_want) begin
          $error("best_score: expected %0d, got %0d", best_want, best_score_o);
          errors++;
        end
      end
    end
  end

  function automatic logic [31:0] reg_mask(int idx);
    return (idx == REG_MATCH) ? 32'h7F : 32'hFF;
  endfunction

  task automatic apb_read_check(input int idx, input logic [31:0] want);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= 4'(4 * idx);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if ((prdata & reg_mask(idx)) !== (want & reg_mask(idx))) begin
      $error("prdata[%0d]: expected %0h, got %0h", idx, want & reg_mask(idx),
             prdata & reg_mask(idx));
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_write(input int idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(4 * idx);
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MATCH:  cfg_match  = int'(val[6:0]);
      REG_ACCENT: cfg_accent = int'($signed(val[7:0]));
      default:    cfg_gap    = int'($signed(val[7:0]));
    endcase
    apb_read_check(idx, val);
  endtask

  task automatic set_scores(input logic [6:0] m, input logic [7:0] a, input logic [7:0] g);
    apb_write(REG_MATCH, 32'(m));
    apb_write(REG_ACCENT, 32'(a));
    apb_write(REG_GAP, 32'(g));
  endtask

  task automatic push_cmd(input logic op, input logic [7:0] sym, input logic lst);
    symbol_cmd_t c;
    c.op  = op;
    c.sym = sym;
    c.lst = lst;
    cmd_q.push_back(c);
    cmds_queued++;
  endtask

  function automatic logic [7:0] accent_byte();
    case ($urandom_range(13))
      0:  return 8'h65;
      1:  return 8'hC3;
      2:  return 8'hA9;
      3:  return 8'h88;
      4:  return 8'h89;
      5:  return 8'h8A;
      6:  return 8'h8B;
      7:  return 8'hA8;
      8:  return 8'hAA;
      9:  return 8'hAB;
      10: return 8'h61;
      11: return 8'hA0;
      12: return 8'hA1;
      default: return 8'hA2;
    endcase
  endfunction

  function automatic logic [7:0] pattern_byte();
    case ($urandom_range(3))
      0, 1: return 8'(65 + $urandom_range(57));
      2:    return accent_byte();
      default: return 8'($urandom);
    endcase
  endfunction

  // text bytes lean on the current pattern so that matches and case folds are common
  function automatic logic [7:0] text_byte();
    logic [7:0] p;
    int unsigned r;
    r = $urandom_range(99);
    if (gen_pat.size() != 0 && r < 55) begin
      p = gen_pat[$urandom_range(gen_pat.size() - 1)];
      case ($urandom_range(2))
        0: return p;
        1: return p + 8'd32;
        default: return p - 8'd32;
      endcase
    end
    if (r < 75) return accent_byte();
    return 8'($urandom);
  endfunction

  function automatic int pattern_len_pick();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(1, 6);
    if (r < 92) return $urandom_range(7, PATTERN_MAX);
    return $urandom_range(PATTERN_MAX + 1, PATTERN_MAX + 8);
  endfunction

  function automatic int text_len_pick();
    return ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
  endfunction

  task automatic load_pattern(input int n, input logic close);
    logic [7:0] b;
    int k;
    gen_pat.delete();
    for (k = 0; k < n; k++) begin
      b = pattern_byte();
      gen_pat.push_back(b);
      push_cmd(OP_PATTERN, b, close && (k == n - 1));
    end
  endtask

  task automatic feed_text(input int n, input logic close);
    int k;
    for (k = 0; k < n; k++) push_cmd(OP_TEXT, text_byte(), close && (k == n - 1));
  endtask

  task automatic random_items(input int n);
    int base;
    int unsigned r;
    base = cmds_queued;
    while (cmds_queued - base < n) begin
      r = $urandom_range(99);
      if (r < 72) begin
        load_pattern(pattern_len_pick(), 1'b1);
        repeat ($urandom_range(1, 3)) feed_text(text_len_pick(), 1'b1);
      end else if (r < 80) begin
        // text cut short by a new pattern
        feed_text(text_len_pick(), 1'b0);
        load_pattern(pattern_len_pick(), 1'b1);
        feed_text(text_len_pick(), 1'b1);
      end else if (r < 88) begin
        // pattern left open, closed by the first text byte
        load_pattern(pattern_len_pick(), 1'b0);
        feed_text(text_len_pick(), 1'b1);
      end else if (r < 94) begin
        feed_text(text_len_pick(), 1'b1);
      end else begin
        repeat ($urandom_range(1, 3)) push_cmd(1'($urandom), 8'($urandom), 1'($urandom));
      end
    end
  endtask

  task automatic drain();
    int waited;
    while (cmds_taken != cmds_queued) @(posedge clk_i);
    waited = 0;
    while (best_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (best_q.size() != 0) begin
      $error("best_score: %0d expected results never arrived", best_q.size());
      errors++;
      best_q.delete();
    end
    while (busy) @(posedge clk_i);
    repeat (LAT_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_read_check(REG_MATCH, 32'(fas_pkg::MATCH_RST));
    apb_read_check(REG_ACCENT, 32'(fas_pkg::ACCENT_RST));
    apb_read_check(REG_GAP, 32'(fas_pkg::GAP_RST));

    // directed: empty pattern, signed case folding, accent sets, restarts
    idle_pct = 0;
    push_cmd(OP_TEXT, 8'h00, 1'b1);
    push_cmd(OP_PATTERN, 8'h41, 1'b0);
    push_cmd(OP_PATTERN, 8'hF0, 1'b0);
    push_cmd(OP_PATTERN, 8'h65, 1'b0);
    push_cmd(OP_PATTERN, 8'h61, 1'b0);
    push_cmd(OP_PATTERN, 8'h00, 1'b0);
    push_cmd(OP_PATTERN, 8'hFF, 1'b0);
    push_cmd(OP_PATTERN, 8'h70, 1'b0);
    push_cmd(OP_PATTERN, 8'hC3, 1'b1);
    push_cmd(OP_TEXT, 8'h61, 1'b0);
    push_cmd(OP_TEXT, 8'h10, 1'b0);
    push_cmd(OP_TEXT, 8'hA9, 1'b0);
    push_cmd(OP_TEXT, 8'hA0, 1'b0);
    push_cmd(OP_TEXT, 8'h90, 1'b0);
    push_cmd(OP_TEXT, 8'h80, 1'b0);
    push_cmd(OP_TEXT, 8'h7F, 1'b0);
    push_cmd(OP_TEXT, 8'hC3, 1'b1);
    push_cmd(OP_TEXT, 8'h41, 1'b0);
    push_cmd(OP_PATTERN, 8'h41, 1'b0);
    push_cmd(OP_PATTERN, 8'h42, 1'b1);
    push_cmd(OP_TEXT, 8'h61, 1'b1);
    push_cmd(OP_PATTERN, 8'h55, 1'b0);
    push_cmd(OP_TEXT, 8'h75, 1'b1);
    push_cmd(OP_TEXT, 8'h55, 1'b1);
    drain();

    set_scores(7'($urandom), 8'($urandom), 8'($urandom));
    idle_pct = 0;
    random_items(100);
    drain();

    set_scores(7'd0, 8'h80, 8'h80);
    idle_pct = 68;
    random_items(90);
    drain();

    // positive gaps drive cells into saturation over a long text
    set_scores(7'd127, 8'h7F, 8'h7F);
    idle_pct = 24;
    load_pattern(PATTERN_MAX, 1'b1);
    feed_text(240, 1'b1);
    drain();

    set_scores(7'($urandom), 8'($urandom), 8'($urandom));
    idle_pct = 24;
    random_items(90);
    drain();

    set_scores(7'd127, 8'h80, 8'h00);
    idle_pct = 68;
    random_items(90);
    drain();

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
